>>> src/ptcm_pkg.sv
// Shared types, codes and constants of the two-point pH calibration meter.
package ptcm_pkg;

  localparam int SAMPLE_W = 16;
  localparam int VOLT_W   = 16;
  localparam int PH_W     = 18;
  localparam int KIND_W   = 2;
  localparam int MSG_W    = 3;
  localparam int STEP_W   = 2;
  localparam int CAL_W    = 2;
  localparam int CFG_IDX_W = 1;

  localparam logic [KIND_W-1:0] KIND_MEASURE   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_CALIBRATE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_RESTART   = 2'd2;
  localparam logic [KIND_W-1:0] KIND_UNUSED    = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_NEUTRAL = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACID    = 1'd1;

  localparam logic [CAL_W-1:0] CAL_IDLE     = 2'd0;
  localparam logic [CAL_W-1:0] CAL_ENTERED  = 2'd1;
  localparam logic [CAL_W-1:0] CAL_CAPTURED = 2'd2;

  localparam logic [MSG_W-1:0] MSG_NEED_CAL    = 3'd0;
  localparam logic [MSG_W-1:0] MSG_ENTERED     = 3'd1;
  localparam logic [MSG_W-1:0] MSG_GOT_NEUTRAL = 3'd2;
  localparam logic [MSG_W-1:0] MSG_GOT_ACID    = 3'd3;
  localparam logic [MSG_W-1:0] MSG_BUFFER_ERR  = 3'd4;
  localparam logic [MSG_W-1:0] MSG_SUCCESS     = 3'd5;
  localparam logic [MSG_W-1:0] MSG_FAILED      = 3'd6;

  localparam logic [STEP_W-1:0] STEP_NONE     = 2'd0;
  localparam logic [STEP_W-1:0] STEP_ENTERED  = 2'd1;
  localparam logic [STEP_W-1:0] STEP_CAPTURED = 2'd2;
  localparam logic [STEP_W-1:0] STEP_DONE     = 2'd3;

  localparam logic [VOLT_W-1:0] NEUTRAL_RESET = 16'd15000;
  localparam logic [VOLT_W-1:0] ACID_RESET    = 16'd20324;

  localparam logic [VOLT_W-1:0] NEUT_LO = 16'd13220;
  localparam logic [VOLT_W-1:0] NEUT_HI = 16'd16780;
  localparam logic [VOLT_W-1:0] ACID_LO = 16'd18540;
  localparam logic [VOLT_W-1:0] ACID_HI = 16'd22100;

  localparam int CONV_SCALE = 66000;
  localparam int PH_SCALE   = 6000;
  localparam logic signed [19:0] PH_NEUTRAL = 20'sd7000;
  localparam logic signed [19:0] PH_LIMIT_HI = 20'sd100000;
  localparam logic signed [19:0] PH_LIMIT_LO = -20'sd100000;

  localparam int DIV_NUM_W = 33;
  localparam int DIV_DEN_W = 17;
  localparam int DIV_Q_W   = 18;
  localparam int DIV_HI_W  = DIV_NUM_W - DIV_Q_W;
  localparam int DIV_STEPS = DIV_Q_W / 2;
  localparam int DIV_CNT_W = 4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV_MUL,
    ST_CONV_DIV,
    ST_CONV_WAIT,
    ST_PH_MUL,
    ST_PH_DIV,
    ST_PH_WAIT,
    ST_OUT
  } ctrl_state_t;

  typedef struct packed {
    logic accept;
    logic conv_mul;
    logic ph_mul;
    logic div_start;
    logic take_v;
    logic commit;
  } dp_cmd_t;

  typedef struct packed {
    logic div_busy;
    logic div_done;
    logic need_ph;
  } dp_status_t;

endpackage

>>> src/ptcm_in_if.sv
// Input item channel: kind and raw probe sample.
interface ptcm_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [15:0] adc_sample;

  modport source (output valid, output kind, output adc_sample, input ready);
  modport sink (input valid, input kind, input adc_sample, output ready);
endinterface

>>> src/ptcm_out_if.sv
// Result item channel: pH, voltage, calibration status and save request.
interface ptcm_out_if;
  logic               valid;
  logic               ready;
  logic signed [17:0] ph_milli;
  logic               ph_error;
  logic [15:0]        voltage_tenths;
  logic               calibrated;
  logic [2:0]         message_code;
  logic [1:0]         step_number;
  logic               save_request;
  logic               save_slot;
  logic [15:0]        save_value;

  modport source (output valid, output ph_milli, output ph_error, output voltage_tenths,
                  output calibrated, output message_code, output step_number,
                  output save_request, output save_slot, output save_value, input ready);
  modport sink (input valid, input ph_milli, input ph_error, input voltage_tenths,
                input calibrated, input message_code, input step_number,
                input save_request, input save_slot, input save_value, output ready);
endinterface

>>> src/ptcm_ctrl.sv
// Controller state machine sequencing conversion, pH division and result hand-off.
module ptcm_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  output ptcm_pkg::dp_cmd_t    cmd,
  input  ptcm_pkg::dp_status_t status
);
  import ptcm_pkg::*;

  ctrl_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = ST_CONV_MUL;
        end
      end
      ST_CONV_MUL: begin
        cmd.conv_mul = 1'b1;
        state_nxt    = ST_CONV_DIV;
      end
      ST_CONV_DIV: begin
        cmd.div_start = 1'b1;
        state_nxt     = ST_CONV_WAIT;
      end
      ST_CONV_WAIT: begin
        if (status.div_done) begin
          cmd.take_v = 1'b1;
          state_nxt  = status.need_ph ? ST_PH_MUL : ST_OUT;
        end
      end
      ST_PH_MUL: begin
        cmd.ph_mul = 1'b1;
        state_nxt  = ST_PH_DIV;
      end
      ST_PH_DIV: begin
        cmd.div_start = 1'b1;
        state_nxt     = ST_PH_WAIT;
      end
      ST_PH_WAIT: begin
        if (status.div_done) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_r || out_ready) begin
          cmd.commit = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign out_valid = out_valid_r;

endmodule

>>> src/ptcm_divider.sv
// Iterative restoring divider, two quotient bits per cycle, with overflow flag.
module ptcm_divider (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic [ptcm_pkg::DIV_NUM_W-1:0]  num,
  input  logic [ptcm_pkg::DIV_DEN_W-1:0]  den,
  output logic                            busy,
  output logic                            done,
  output logic [ptcm_pkg::DIV_Q_W-1:0]    quot,
  output logic                            ovf
);
  import ptcm_pkg::*;

  logic                 busy_r, done_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [DIV_DEN_W-1:0] rem_r, den_r;
  logic [DIV_Q_W-1:0]   q_r;
  logic                 ovf_r;

  logic [DIV_DEN_W:0]   r_a, t_a, r_b, t_b;
  logic                 ge_a, ge_b;
  logic [DIV_DEN_W-1:0] rem_a, rem_b;
  logic [DIV_Q_W-1:0]   q_nxt;

  always_comb begin
    r_a   = {rem_r, q_r[DIV_Q_W-1]};
    ge_a  = r_a >= {1'b0, den_r};
    t_a   = ge_a ? r_a - {1'b0, den_r} : r_a;
    rem_a = t_a[DIV_DEN_W-1:0];
    r_b   = {rem_a, q_r[DIV_Q_W-2]};
    ge_b  = r_b >= {1'b0, den_r};
    t_b   = ge_b ? r_b - {1'b0, den_r} : r_b;
    rem_b = t_b[DIV_DEN_W-1:0];
    q_nxt = {q_r[DIV_Q_W-3:0], ge_a, ge_b};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= DIV_CNT_W'(DIV_STEPS - 1);
      end else if (busy_r) begin
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= DIV_DEN_W'(num[DIV_NUM_W-1:DIV_Q_W]);
      q_r   <= num[DIV_Q_W-1:0];
      den_r <= den;
      ovf_r <= DIV_DEN_W'(num[DIV_NUM_W-1:DIV_Q_W]) >= den;
    end else if (busy_r) begin
      rem_r <= rem_b;
      q_r   <= q_nxt;
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign quot = q_r;
  assign ovf  = ovf_r;

endmodule

>>> src/ptcm_datapath.sv
// Datapath: voltage conversion, pH arithmetic, calibration state and result registers.
module ptcm_datapath #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  ptcm_pkg::dp_cmd_t                   cmd,
  output ptcm_pkg::dp_status_t                status,
  input  logic [ptcm_pkg::KIND_W-1:0]         in_kind,
  input  logic [ptcm_pkg::SAMPLE_W-1:0]       in_sample,
  input  logic                                cfg_we,
  input  logic [ptcm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ptcm_pkg::VOLT_W-1:0]         cfg_data,
  output logic signed [ptcm_pkg::PH_W-1:0]    out_ph_milli,
  output logic                                out_ph_error,
  output logic [ptcm_pkg::VOLT_W-1:0]         out_voltage_tenths,
  output logic                                out_calibrated,
  output logic [ptcm_pkg::MSG_W-1:0]          out_message_code,
  output logic [ptcm_pkg::STEP_W-1:0]         out_step_number,
  output logic                                out_save_request,
  output logic                                out_save_slot,
  output logic [ptcm_pkg::VOLT_W-1:0]         out_save_value
);
  import ptcm_pkg::*;

  localparam logic [DIV_NUM_W-1:0] CONV_FS =
    DIV_NUM_W'((64'd1 << SAMPLE_BITS) - 64'd1);
  localparam logic [DIV_DEN_W-1:0] CONV_DEN =
    DIV_DEN_W'((64'd1 << (SAMPLE_BITS + 1)) - 64'd2);

  logic [KIND_W-1:0]      kind_r;
  logic [SAMPLE_BITS-1:0] sample_r;
  logic [DIV_NUM_W-1:0]   prod_r, prod_nxt;
  logic [DIV_DEN_W-1:0]   den_r, den_nxt;
  logic [VOLT_W-1:0]      v_r;
  logic                   neg_r;

  logic [VOLT_W-1:0] wn_r, wn_nxt, wa_r, wa_nxt;
  logic [CAL_W-1:0]  cal_r, cal_nxt;
  logic              entered_r, entered_nxt;
  logic              finished_r, finished_nxt;
  logic              calib_r, calib_nxt;
  logic [MSG_W-1:0]  msg_r, msg_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;

  logic                  div_busy, div_done, div_ovf;
  logic [DIV_Q_W-1:0]    div_quot;

  logic [VOLT_W-1:0]     abs_d, abs_vn;
  logic                  neg_now, d_zero, in_neut, in_acid;
  logic signed [19:0]    ph_raw;
  logic signed [PH_W-1:0] ph_res;
  logic                  err_res;
  logic                  save_res, slot_res;
  logic [VOLT_W-1:0]     sval_res;

  ptcm_divider u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (prod_r),
    .den   (den_r),
    .busy  (div_busy),
    .done  (div_done),
    .quot  (div_quot),
    .ovf   (div_ovf)
  );

  always_comb begin
    abs_d   = (wn_r >= wa_r) ? wn_r - wa_r : wa_r - wn_r;
    abs_vn  = (v_r >= wn_r) ? v_r - wn_r : wn_r - v_r;
    neg_now = (v_r < wn_r) ^ (wn_r < wa_r);
    d_zero  = (wn_r == wa_r);
    in_neut = (v_r > NEUT_LO) && (v_r < NEUT_HI);
    in_acid = (v_r > ACID_LO) && (v_r < ACID_HI);
  end

  always_comb begin
    prod_nxt = prod_r;
    den_nxt  = den_r;
    if (cmd.conv_mul) begin
      prod_nxt = DIV_NUM_W'(sample_r) * DIV_NUM_W'(CONV_SCALE) + CONV_FS;
      den_nxt  = CONV_DEN;
    end else if (cmd.ph_mul) begin
      prod_nxt = DIV_NUM_W'(abs_vn) * DIV_NUM_W'(PH_SCALE) + DIV_NUM_W'(abs_d);
      den_nxt  = {abs_d, 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      kind_r   <= in_kind;
      sample_r <= in_sample[SAMPLE_BITS-1:0];
    end
    prod_r <= prod_nxt;
    den_r  <= den_nxt;
    if (cmd.take_v) begin
      v_r <= div_quot[VOLT_W-1:0];
    end
    if (cmd.ph_mul) begin
      neg_r <= neg_now;
    end
  end

  always_comb begin
    ph_raw  = neg_r ? PH_NEUTRAL - $signed({2'b00, div_quot})
                    : PH_NEUTRAL + $signed({2'b00, div_quot});
    ph_res  = '0;
    err_res = 1'b0;
    if (kind_r == KIND_MEASURE) begin
      if (d_zero) begin
        err_res = 1'b1;
      end else if (div_ovf) begin
        ph_res = neg_r ? PH_W'(PH_LIMIT_LO) : PH_W'(PH_LIMIT_HI);
      end else if (ph_raw > PH_LIMIT_HI) begin
        ph_res = PH_W'(PH_LIMIT_HI);
      end else if (ph_raw < PH_LIMIT_LO) begin
        ph_res = PH_W'(PH_LIMIT_LO);
      end else begin
        ph_res = PH_W'(ph_raw);
      end
    end
  end

  always_comb begin
    wn_nxt       = wn_r;
    wa_nxt       = wa_r;
    cal_nxt      = cal_r;
    entered_nxt  = entered_r;
    finished_nxt = finished_r;
    calib_nxt    = calib_r;
    msg_nxt      = msg_r;
    step_nxt     = step_r;
    save_res     = 1'b0;
    slot_res     = 1'b0;
    sval_res     = '0;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_NEUTRAL: wn_nxt = cfg_data;
        CFG_ACID:    wa_nxt = cfg_data;
        default:     ;
      endcase
    end else if (cmd.commit) begin
      unique case (kind_r)
        KIND_MEASURE: ;
        KIND_CALIBRATE: begin
          unique case (cal_r)
            CAL_IDLE: begin
              calib_nxt    = 1'b0;
              entered_nxt  = 1'b1;
              finished_nxt = 1'b0;
              msg_nxt      = MSG_ENTERED;
              cal_nxt      = CAL_ENTERED;
              step_nxt     = STEP_ENTERED;
            end
            CAL_ENTERED: begin
              if (entered_r) begin
                if (in_neut) begin
                  wn_nxt       = v_r;
                  finished_nxt = 1'b1;
                  msg_nxt      = MSG_GOT_NEUTRAL;
                  step_nxt     = STEP_CAPTURED;
                end else if (in_acid) begin
                  wa_nxt       = v_r;
                  finished_nxt = 1'b1;
                  msg_nxt      = MSG_GOT_ACID;
                  step_nxt     = STEP_CAPTURED;
                end else begin
                  finished_nxt = 1'b0;
                  msg_nxt      = MSG_BUFFER_ERR;
                end
                cal_nxt = CAL_CAPTURED;
              end
            end
            CAL_CAPTURED: begin
              if (entered_r) begin
                if (finished_r) begin
                  if (in_neut) begin
                    save_res = 1'b1;
                    slot_res = 1'b0;
                    sval_res = wn_r;
                  end else if (in_acid) begin
                    save_res = 1'b1;
                    slot_res = 1'b1;
                    sval_res = wa_r;
                  end
                  calib_nxt = 1'b1;
                  msg_nxt   = MSG_SUCCESS;
                  step_nxt  = STEP_DONE;
                end else begin
                  cal_nxt   = CAL_IDLE;
                  calib_nxt = 1'b0;
                  msg_nxt   = MSG_FAILED;
                  step_nxt  = STEP_NONE;
                end
                finished_nxt = 1'b0;
                entered_nxt  = 1'b0;
              end
            end
            default: ;
          endcase
        end
        KIND_RESTART: begin
          cal_nxt  = CAL_IDLE;
          step_nxt = STEP_NONE;
          msg_nxt  = MSG_NEED_CAL;
        end
        KIND_UNUSED: ;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wn_r       <= NEUTRAL_RESET;
      wa_r       <= ACID_RESET;
      cal_r      <= CAL_IDLE;
      entered_r  <= 1'b0;
      finished_r <= 1'b0;
      calib_r    <= 1'b0;
      msg_r      <= MSG_NEED_CAL;
      step_r     <= STEP_NONE;
    end else begin
      wn_r       <= wn_nxt;
      wa_r       <= wa_nxt;
      cal_r      <= cal_nxt;
      entered_r  <= entered_nxt;
      finished_r <= finished_nxt;
      calib_r    <= calib_nxt;
      msg_r      <= msg_nxt;
      step_r     <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_ph_milli       <= ph_res;
      out_ph_error       <= err_res;
      out_voltage_tenths <= v_r;
      out_calibrated     <= calib_nxt;
      out_message_code   <= msg_nxt;
      out_step_number    <= step_nxt;
      out_save_request   <= save_res;
      out_save_slot      <= slot_res;
      out_save_value     <= sval_res;
    end
  end

  assign status.div_busy = div_busy;
  assign status.div_done = div_done;
  assign status.need_ph  = (kind_r == KIND_MEASURE) && !d_zero;

endmodule

>>> src/ph_two_point_calibration_meter_unit.sv
// Top level of the two-point pH calibration meter.
// Measure items with distinct calibration voltages pass the voltage and the pH division;
// other items only the voltage one. A new item is taken once the last is committed.
// The shared divider, two quotient bits a cycle, serves both the voltage and the pH division.
// A finished result waits in the output register while the next item is taken.
// Synchronous active-low reset clears the calibration state and loads default voltages.
module ph_two_point_calibration_meter_unit #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  ptcm_in_if.sink                          in_if,
  ptcm_out_if.source                       out_if,
  input  logic                             cfg_we,
  input  logic [ptcm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ptcm_pkg::VOLT_W-1:0]      cfg_data
);
  import ptcm_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  ptcm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_ready  (in_if.ready),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .cmd       (cmd),
    .status    (status)
  );

  ptcm_datapath #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .status             (status),
    .in_kind            (in_if.kind),
    .in_sample          (in_if.adc_sample),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .out_ph_milli       (out_if.ph_milli),
    .out_ph_error       (out_if.ph_error),
    .out_voltage_tenths (out_if.voltage_tenths),
    .out_calibrated     (out_if.calibrated),
    .out_message_code   (out_if.message_code),
    .out_step_number    (out_if.step_number),
    .out_save_request   (out_if.save_request),
    .out_save_slot      (out_if.save_slot),
    .out_save_value     (out_if.save_value)
  );

  a_commit_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> (!out_if.valid || out_if.ready))
    else $error("result committed over an untaken item");

  a_one_item_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_if.valid && in_if.ready) |=> !in_if.ready)
    else $error("input ready straight after acceptance");

  a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |-> !status.div_busy)
    else $error("divider restarted while busy");

  a_valid_after_commit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_if.valid) |-> $past(cmd.commit))
    else $error("output valid without a committed item");

endmodule
